// ===== src/vwuf_pkg.sv =====
`timescale 1ns / 1ps
// shared types and codes for the vertex weld core
// no dependencies

package vwuf_pkg;

   typedef enum logic [2:0] {
      ACT_LOAD    = 3'd0,
      ACT_CLUSTER = 3'd1,
      ACT_MAP     = 3'd2,
      ACT_READ    = 3'd3,
      ACT_CLEAR   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STS_OK          = 2'd0,
      STS_FULL        = 2'd1,
      STS_RANGE       = 2'd2,
      STS_UNCLUSTERED = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic [9:0]         query_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [10:0]        unique_total;
      logic [9:0]         mapped_index;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_CAPTURE,
      OP_LOAD,
      OP_CLEAR,
      OP_QERR,
      OP_MAP_LABEL,
      OP_READ_REP,
      OP_LABEL_TO_REP,
      OP_REP_TO_STORE,
      OP_RESP_VERT,
      OP_CL_INIT,
      OP_INIT_WR,
      OP_I_ZERO,
      OP_RD_I,
      OP_HOLD_I,
      OP_RD_J,
      OP_WALK_I,
      OP_WALK_J,
      OP_WALK,
      OP_LINK,
      OP_NEXT_J,
      OP_NEXT_I,
      OP_LBL_NEW,
      OP_LBL_RD,
      OP_LBL_COPY,
      OP_CL_DONE
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_Q_LABEL,
      S_Q_REP,
      S_Q_STORE,
      S_INIT,
      S_OUTER,
      S_HOLD_I,
      S_INNER,
      S_CMP1,
      S_CMP2,
      S_CMP3,
      S_CMP4,
      S_DECIDE,
      S_FIND_A,
      S_FIND_B,
      S_NEXT,
      S_LABEL,
      S_LBL_FIND,
      S_LBL_WAIT
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0] action;
      logic       full;
      logic       q_err;
      logic       near;
      logic       root_found;
      logic       walk_is_i;
      logic       i_done;
      logic       i_last;
      logic       j_last;
   } dp_status_type;

endpackage

// ===== src/vertex_weld_union_find_core.sv =====
`timescale 1ns / 1ps
// top level of the vertex weld core: sequencer plus datapath
// depends on vwuf_pkg, vwuf_ctrl, vwuf_datapath

// Items are taken when start is high and busy is low; each item that has a
// result returns it on rsp_data for one cycle with rsp_valid, and the
// receiver must take it then. Load, clear and rejected queries give their
// result straight from the decode step; map and read go on through the
// registered reads of the label, representative and vertex memories in turn
// (read starts at the representative memory). Cluster on n vertices runs the
// link reset, then the pairwise sweep (one pair through the distance pipeline
// at a time), then the labelling pass, with a walk up the link memory for
// each near pair and for each labelled vertex. Codes 5 to 7 give no result.
// The tolerance register is always ready and is to be written only while the
// core is idle; the core itself does not enforce this.

module vertex_weld_union_find_core import vwuf_pkg::*; #(
   parameter int MAX_VERTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_data
);

   op_type        op;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   vwuf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .dp_status(dp_status),
      .busy(busy), .op(op));

   vwuf_datapath #(.MAX_VERTS(MAX_VERTS)) u_datapath (
      .clock(clock), .reset(reset), .op(op), .req_data(req_data),
      .csr_wr(csr_valid && csr_ready), .csr_data(csr_data),
      .dp_status(dp_status), .rsp_valid(rsp_valid), .rsp_data(rsp_data));

   // a result always needs a decode step after the accept
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("back to back results");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result while still busy");
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted item not taken up");

endmodule

// ===== src/vwuf_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module vwuf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/vwuf_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for the vertex weld core: issues one datapath op per cycle
// depends on vwuf_pkg

module vwuf_ctrl import vwuf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type dp_status,
   output logic          busy,
   output op_type        op
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op       = OP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op       = OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            case (dp_status.action)
               ACT_LOAD:  op = OP_LOAD;
               ACT_CLEAR: op = OP_CLEAR;
               ACT_CLUSTER: begin
                  op       = OP_CL_INIT;
                  state_in = S_INIT;
               end
               ACT_MAP: begin
                  if (dp_status.q_err) begin
                     op = OP_QERR;
                  end else begin
                     op       = OP_MAP_LABEL;
                     state_in = S_Q_LABEL;
                  end
               end
               ACT_READ: begin
                  if (dp_status.q_err) begin
                     op = OP_QERR;
                  end else begin
                     op       = OP_READ_REP;
                     state_in = S_Q_REP;
                  end
               end
               default: op = OP_NOP;
            endcase
         end
         S_Q_LABEL: begin
            op       = OP_LABEL_TO_REP;
            state_in = S_Q_REP;
         end
         S_Q_REP: begin
            op       = OP_REP_TO_STORE;
            state_in = S_Q_STORE;
         end
         S_Q_STORE: begin
            op       = OP_RESP_VERT;
            state_in = S_IDLE;
         end
         S_INIT: begin
            if (dp_status.i_done) begin
               op       = OP_I_ZERO;
               state_in = S_OUTER;
            end else begin
               op = OP_INIT_WR;
            end
         end
         S_OUTER: begin
            if (dp_status.i_last) begin
               op       = OP_I_ZERO;
               state_in = S_LABEL;
            end else begin
               op       = OP_RD_I;
               state_in = S_HOLD_I;
            end
         end
         S_HOLD_I: begin
            op       = OP_HOLD_I;
            state_in = S_INNER;
         end
         S_INNER: begin
            op       = OP_RD_J;
            state_in = S_CMP1;
         end
         // distance pipeline runs on its own, just wait it out
         S_CMP1: state_in = S_CMP2;
         S_CMP2: state_in = S_CMP3;
         S_CMP3: state_in = S_CMP4;
         S_CMP4: state_in = S_DECIDE;
         S_DECIDE: begin
            if (dp_status.near) begin
               op       = OP_WALK_I;
               state_in = S_FIND_A;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_FIND_A: begin
            if (dp_status.root_found) begin
               op       = OP_WALK_J;
               state_in = S_FIND_B;
            end else begin
               op = OP_WALK;
            end
         end
         S_FIND_B: begin
            if (dp_status.root_found) begin
               op       = OP_LINK;
               state_in = S_NEXT;
            end else begin
               op = OP_WALK;
            end
         end
         S_NEXT: begin
            if (dp_status.j_last) begin
               op       = OP_NEXT_I;
               state_in = S_OUTER;
            end else begin
               op       = OP_NEXT_J;
               state_in = S_INNER;
            end
         end
         S_LABEL: begin
            if (dp_status.i_done) begin
               op       = OP_CL_DONE;
               state_in = S_IDLE;
            end else begin
               op       = OP_WALK_I;
               state_in = S_LBL_FIND;
            end
         end
         S_LBL_FIND: begin
            if (!dp_status.root_found) begin
               op = OP_WALK;
            end else if (dp_status.walk_is_i) begin
               op       = OP_LBL_NEW;
               state_in = S_LABEL;
            end else begin
               op       = OP_LBL_RD;
               state_in = S_LBL_WAIT;
            end
         end
         S_LBL_WAIT: begin
            op       = OP_LBL_COPY;
            state_in = S_LABEL;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== src/vwuf_datapath.sv =====
`timescale 1ns / 1ps
// datapath of the vertex weld core: vertex store, union-find links, labels,
// distance pipeline and result register; depends on vwuf_pkg and vwuf_ram

module vwuf_datapath import vwuf_pkg::*; #(
   parameter int MAX_VERTS = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  op_type        op,
   input  req_type       req_data,
   input  logic          csr_wr,
   input  logic [30:0]   csr_data,
   output dp_status_type dp_status,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   localparam int IW = $clog2(MAX_VERTS);
   localparam int CW = $clog2(MAX_VERTS + 1);

   req_type          req_ff, req_in;
   logic [30:0]      eps_ff, eps_in;
   logic [61:0]      eps_sq_ff, eps_sq_in;
   logic [CW-1:0]    loaded_ff, loaded_in;
   logic [CW-1:0]    merged_ff, merged_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    j_ff, j_in;
   logic             clustered_ff, clustered_in;
   logic [IW-1:0]    walk_ff, walk_in;
   logic [IW-1:0]    root_a_ff, root_a_in;
   logic [IW-1:0]    mapped_ff, mapped_in;
   logic [95:0]      hold_ff, hold_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // distance pipeline, free running
   logic signed [32:0] dx1_ff, dy1_ff, dz1_ff;
   logic               eq1_ff, eq2_ff, eq3_ff;
   logic [32:0]        ax2_ff, ay2_ff, az2_ff;
   logic               far3_ff;
   logic [61:0]        sqx3_ff, sqy3_ff, sqz3_ff;
   logic               near_ff;
   logic [32:0]        abs_x, abs_y, abs_z;
   logic [63:0]        sq_sum;

   // ram ports
   logic          st_we, rt_we, nl_we, rp_we;
   logic [IW-1:0] st_wa, rt_wa, nl_wa, rp_wa;
   logic [IW-1:0] st_ra, rt_ra, nl_ra, rp_ra;
   logic [95:0]   st_wd, st_rd;
   logic [IW-1:0] rt_wd, rt_rd, nl_wd, nl_rd, rp_wd, rp_rd;

   logic          full;
   logic [31:0]   q_wide;
   logic [IW-1:0] q_addr;

   vwuf_ram #(.WIDTH(96), .DEPTH(MAX_VERTS)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd));
   vwuf_ram #(.WIDTH(IW), .DEPTH(MAX_VERTS)) u_root (
      .clock(clock), .wr_en(rt_we), .wr_addr(rt_wa), .wr_data(rt_wd),
      .rd_addr(rt_ra), .rd_data(rt_rd));
   vwuf_ram #(.WIDTH(IW), .DEPTH(MAX_VERTS)) u_label (
      .clock(clock), .wr_en(nl_we), .wr_addr(nl_wa), .wr_data(nl_wd),
      .rd_addr(nl_ra), .rd_data(nl_rd));
   vwuf_ram #(.WIDTH(IW), .DEPTH(MAX_VERTS)) u_rep (
      .clock(clock), .wr_en(rp_we), .wr_addr(rp_wa), .wr_data(rp_wd),
      .rd_addr(rp_ra), .rd_data(rp_rd));

   assign full   = (loaded_ff >= CW'(MAX_VERTS));
   assign q_wide = 32'(req_ff.query_index);
   assign q_addr = IW'(req_ff.query_index);

   always_comb begin
      dp_status.action     = req_ff.action;
      dp_status.full       = full;
      dp_status.q_err      = !clustered_ff ||
                             ((req_ff.action == ACT_MAP) ? (q_wide >= 32'(loaded_ff))
                                                         : (q_wide >= 32'(merged_ff)));
      dp_status.near       = near_ff;
      dp_status.root_found = (rt_rd == walk_ff);
      dp_status.walk_is_i  = (walk_ff == i_ff[IW-1:0]);
      dp_status.i_done     = (i_ff == loaded_ff);
      dp_status.i_last     = ((CW+1)'(i_ff) + (CW+1)'(1)) >= (CW+1)'(loaded_ff);
      dp_status.j_last     = ((CW+1)'(j_ff) + (CW+1)'(1)) >= (CW+1)'(loaded_ff);
   end

   // pipeline: signed difference, magnitude, square, sum and compare, with an exact match when the tolerance is zero
   always_comb begin
      abs_x  = dx1_ff[32] ? 33'(-dx1_ff) : 33'(dx1_ff);
      abs_y  = dy1_ff[32] ? 33'(-dy1_ff) : 33'(dy1_ff);
      abs_z  = dz1_ff[32] ? 33'(-dz1_ff) : 33'(dz1_ff);
      sq_sum = 64'(sqx3_ff) + 64'(sqy3_ff) + 64'(sqz3_ff);
   end

   always_ff @(posedge clock) begin
      dx1_ff  <= $signed({hold_ff[95], hold_ff[95:64]}) - $signed({st_rd[95], st_rd[95:64]});
      dy1_ff  <= $signed({hold_ff[63], hold_ff[63:32]}) - $signed({st_rd[63], st_rd[63:32]});
      dz1_ff  <= $signed({hold_ff[31], hold_ff[31:0]}) - $signed({st_rd[31], st_rd[31:0]});
      eq1_ff  <= (hold_ff == st_rd);
      ax2_ff  <= abs_x;
      ay2_ff  <= abs_y;
      az2_ff  <= abs_z;
      eq2_ff  <= eq1_ff;
      far3_ff <= (ax2_ff >= 33'(eps_ff)) || (ay2_ff >= 33'(eps_ff)) ||
                 (az2_ff >= 33'(eps_ff));
      sqx3_ff <= ax2_ff[30:0] * ax2_ff[30:0];
      sqy3_ff <= ay2_ff[30:0] * ay2_ff[30:0];
      sqz3_ff <= az2_ff[30:0] * az2_ff[30:0];
      eq3_ff  <= eq2_ff;
      near_ff <= (eps_ff == 31'd0) ? eq3_ff : (!far3_ff && (sq_sum < 64'(eps_sq_ff)));
   end

   always_comb begin
      req_in       = req_ff;
      eps_in       = csr_wr ? csr_data : eps_ff;
      eps_sq_in    = eps_sq_ff;
      loaded_in    = loaded_ff;
      merged_in    = merged_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      clustered_in = clustered_ff;
      walk_in      = walk_ff;
      root_a_in    = root_a_ff;
      mapped_in    = mapped_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      st_we = 1'b0;  st_wa = loaded_ff[IW-1:0];
      st_wd = {req_ff.coord_x, req_ff.coord_y, req_ff.coord_z};
      st_ra = rp_rd;
      rt_we = 1'b0;  rt_wa = i_ff[IW-1:0];  rt_wd = i_ff[IW-1:0];
      rt_ra = rt_rd;
      nl_we = 1'b0;  nl_wa = i_ff[IW-1:0];  nl_wd = count_ff[IW-1:0];
      nl_ra = walk_ff;
      rp_we = 1'b0;  rp_wa = count_ff[IW-1:0];  rp_wd = i_ff[IW-1:0];
      rp_ra = nl_rd;

      case (op)
         OP_CAPTURE: req_in = req_data;
         OP_LOAD: begin
            rsp_valid_in        = 1'b1;
            rsp_in              = '0;
            if (full) begin
               rsp_in.status       = STS_FULL;
               rsp_in.unique_total = 11'(merged_ff);
            end else begin
               st_we        = 1'b1;
               loaded_in    = loaded_ff + CW'(1);
               merged_in    = '0;
               clustered_in = 1'b0;
               rsp_in.status = STS_OK;
            end
         end
         OP_CLEAR: begin
            loaded_in    = '0;
            merged_in    = '0;
            clustered_in = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
         end
         OP_QERR: begin
            rsp_valid_in        = 1'b1;
            rsp_in              = '0;
            rsp_in.status       = clustered_ff ? STS_RANGE : STS_UNCLUSTERED;
            rsp_in.unique_total = 11'(merged_ff);
         end
         OP_MAP_LABEL: nl_ra = q_addr;
         OP_READ_REP: begin
            rp_ra     = q_addr;
            mapped_in = q_addr;
         end
         OP_LABEL_TO_REP: begin
            rp_ra     = nl_rd;
            mapped_in = nl_rd;
         end
         OP_REP_TO_STORE: st_ra = rp_rd;
         OP_RESP_VERT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = STS_OK;
            rsp_in.unique_total = 11'(merged_ff);
            rsp_in.mapped_index = 10'(mapped_ff);
            rsp_in.out_x        = st_rd[95:64];
            rsp_in.out_y        = st_rd[63:32];
            rsp_in.out_z        = st_rd[31:0];
         end
         OP_CL_INIT: begin
            i_in      = '0;
            count_in  = '0;
            eps_sq_in = eps_ff * eps_ff;
         end
         OP_INIT_WR: begin
            rt_we = 1'b1;
            i_in  = i_ff + CW'(1);
         end
         OP_I_ZERO: i_in = '0;
         OP_RD_I: begin
            st_ra = i_ff[IW-1:0];
            j_in  = i_ff + CW'(1);
         end
         OP_HOLD_I: hold_in = st_rd;
         OP_RD_J:   st_ra = j_ff[IW-1:0];
         OP_WALK_I: begin
            walk_in = i_ff[IW-1:0];
            rt_ra   = i_ff[IW-1:0];
         end
         OP_WALK_J: begin
            root_a_in = walk_ff;
            walk_in   = j_ff[IW-1:0];
            rt_ra     = j_ff[IW-1:0];
         end
         OP_WALK: begin
            walk_in = rt_rd;
            rt_ra   = rt_rd;
         end
         // larger root points at the smaller one
         OP_LINK: begin
            rt_we = (root_a_ff != walk_ff);
            if (root_a_ff < walk_ff) begin
               rt_wa = walk_ff;
               rt_wd = root_a_ff;
            end else begin
               rt_wa = root_a_ff;
               rt_wd = walk_ff;
            end
         end
         OP_NEXT_J: j_in = j_ff + CW'(1);
         OP_NEXT_I: i_in = i_ff + CW'(1);
         OP_LBL_NEW: begin
            nl_we    = 1'b1;
            rp_we    = 1'b1;
            count_in = count_ff + CW'(1);
            i_in     = i_ff + CW'(1);
         end
         OP_LBL_RD: nl_ra = walk_ff;
         OP_LBL_COPY: begin
            nl_we = 1'b1;
            nl_wd = nl_rd;
            i_in  = i_ff + CW'(1);
         end
         OP_CL_DONE: begin
            merged_in           = count_ff;
            clustered_in        = 1'b1;
            rsp_valid_in        = 1'b1;
            rsp_in              = '0;
            rsp_in.status       = STS_OK;
            rsp_in.unique_total = 11'(count_ff);
         end
         default: rsp_valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff       <= '0;
         loaded_ff    <= '0;
         merged_ff    <= '0;
         clustered_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         eps_ff       <= eps_in;
         loaded_ff    <= loaded_in;
         merged_ff    <= merged_in;
         clustered_ff <= clustered_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      eps_sq_ff <= eps_sq_in;
      count_ff  <= count_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      walk_ff   <= walk_in;
      root_a_ff <= root_a_in;
      mapped_ff <= mapped_in;
      hold_ff   <= hold_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
